// File: rtl/sorted_priority_queue_assert.svh
// Assertion macros used by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);
`define SPQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/spq_pkg.sv
// Types and constants of the sorted priority queue.
package spq_pkg;

  localparam int DEPTH_DEFAULT     = 16;
  localparam int KEY_WIDTH_DEFAULT = 32;

  localparam int FUNC_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_PEEK  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

// File: rtl/spq_if.sv
// Valid/ready channels for operation beats and result beats.
interface spq_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [spq_pkg::FUNC_W-1:0]           func;
  logic signed [spq_pkg::VALUE_W-1:0]   push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink (input valid, input func, input push_value, output ready);
endinterface

interface spq_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [spq_pkg::STATUS_W-1:0]         status;
  logic signed [spq_pkg::VALUE_W-1:0]   result_value;
  logic [spq_pkg::COUNT_W-1:0]          occupancy;
  logic [spq_pkg::COUNT_W-1:0]          cleared_count;

  modport source (output valid, output status, output result_value, output occupancy,
                  output cleared_count, input ready);
  modport sink (input valid, input status, input result_value, input occupancy,
                input cleared_count, output ready);
endinterface

// File: rtl/spq_cell.sv
// One slot of the sorted chain: holds a key and trades it with its neighbors.
module spq_cell #(
  parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  spq_pkg::cell_ctrl_t         ctrl,
  input  logic                        occupied,
  input  logic signed [KEY_WIDTH-1:0] new_key,
  input  logic signed [KEY_WIDTH-1:0] left_key,
  input  logic                        left_gt,
  input  logic signed [KEY_WIDTH-1:0] right_key,
  output logic signed [KEY_WIDTH-1:0] key,
  output logic                        gt
);

  // A stored key larger than the incoming one moves one place to the right.
  assign gt = occupied && (key > new_key);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      // The first cell that is larger or free takes the new key; the rest take
      // the key of their left neighbor.
      if (!occupied || gt) begin
        key <= left_gt ? left_key : new_key;
      end
    end else if (ctrl.pop) begin
      key <= right_key;
    end
  end

endmodule

// File: rtl/sorted_priority_queue.sv
// The result beat is registered and appears in the cycle after its operation beat is accepted.
// Throughput: one operation per cycle while results are taken; every cell compares its key
// with the broadcast push key and shifts in the same cycle, so push and pop each complete in
// a single step of the cell chain, while peek and clear leave the cell keys as they are.
// Reset clears the key count and the result valid flag; cell keys and result fields are not reset.
module sorted_priority_queue #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  spq_req_if.sink  req,
  spq_rsp_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]               count;
  logic [CW-1:0]               count_next;
  logic signed [KEY_WIDTH-1:0] keys [DEPTH];
  logic [DEPTH-1:0]            gts;
  logic signed [KEY_WIDTH-1:0] push_key;
  logic [KEY_WIDTH-1:0]        head_raw;
  spq_pkg::cell_ctrl_t         ctrl;
  logic                        accept;
  logic                        full;
  logic                        empty;

  logic [spq_pkg::STATUS_W-1:0]       status_next;
  logic signed [spq_pkg::VALUE_W-1:0] value_next;
  logic [spq_pkg::COUNT_W-1:0]        cleared_next;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign push_key  = KEY_WIDTH'(req.push_value);
  assign head_raw  = keys[0];

  assign ctrl.push = accept && (req.func == spq_pkg::FUNC_PUSH) && !full;
  assign ctrl.pop  = accept && (req.func == spq_pkg::FUNC_POP) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_WIDTH-1:0] left_key;
    logic                        left_gt;
    logic signed [KEY_WIDTH-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_key = push_key;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_key = keys[i-1];
      assign left_gt  = gts[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_key = keys[i];
    end else begin : g_inner
      assign right_key = keys[i+1];
    end

    spq_cell #(
      .KEY_WIDTH(KEY_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (count > CW'(i)),
      .new_key  (push_key),
      .left_key (left_key),
      .left_gt  (left_gt),
      .right_key(right_key),
      .key      (keys[i]),
      .gt       (gts[i])
    );
  end

  always_comb begin
    count_next   = count;
    status_next  = spq_pkg::STATUS_OK;
    value_next   = '0;
    cleared_next = '0;
    unique case (spq_pkg::func_t'(req.func))
      spq_pkg::FUNC_PUSH: begin
        if (full) begin
          status_next = spq_pkg::STATUS_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      spq_pkg::FUNC_POP, spq_pkg::FUNC_PEEK: begin
        if (empty) begin
          status_next = spq_pkg::STATUS_EMPTY;
        end else begin
          value_next = spq_pkg::VALUE_W'(head_raw);
          if (req.func == spq_pkg::FUNC_POP) begin
            count_next = count - CW'(1);
          end
        end
      end
      spq_pkg::FUNC_CLEAR: begin
        count_next   = '0;
        cleared_next = spq_pkg::COUNT_W'(count);
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status        <= status_next;
      rsp.result_value  <= value_next;
      rsp.occupancy     <= spq_pkg::COUNT_W'(count_next);
      rsp.cleared_count <= cleared_next;
    end
  end

  `include "sorted_priority_queue_assert.svh"

  `SPQ_ASSERT(a_count_bound, count <= CW'(DEPTH), "key count exceeds depth")
  `SPQ_ASSERT(a_full_push, (accept && req.func == spq_pkg::FUNC_PUSH && full) |=> (rsp.status == spq_pkg::STATUS_FULL && count == CW'(DEPTH)), "push on full queue not reported")
  `SPQ_ASSERT(a_clear_empties, (accept && req.func == spq_pkg::FUNC_CLEAR) |=> (count == '0), "clear left keys behind")
  `SPQ_ASSERT(a_pop_count, ctrl.pop |=> (count + CW'(1) == $past(count)), "pop did not remove one key")
  `SPQ_ASSERT_IMPLY(a_head_sorted, count >= CW'(2), keys[0] <= keys[1], "head keys out of order")

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the sorted min-priority queue.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH      = spq_pkg::DEPTH_DEFAULT;
  localparam int RAND_OPS    = 1750;
  localparam int CALM_TAIL   = 200;
  localparam int HOLD_CYCLES = 60;
  localparam int HOLD_AFTER  = 300;

  typedef struct {
    spq_pkg::status_t                    status;
    logic signed [spq_pkg::VALUE_W-1:0]  value;
    logic [spq_pkg::COUNT_W-1:0]         occupancy;
    logic [spq_pkg::COUNT_W-1:0]         cleared;
  } queue_result_t;

  typedef struct {
    spq_pkg::func_t                      op;
    logic signed [spq_pkg::VALUE_W-1:0]  key;
    int                                  reps;
    bit                                  typed;
    queue_result_t                       res;
  } op_row_t;

  typedef struct {
    bit             typed;
    queue_result_t  res;
  } op_tag_t;

  logic clk;
  logic rst;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_queue u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Mirror of the queue contents, ascending, first held_count entries valid.
  logic signed [spq_pkg::VALUE_W-1:0] held_keys [QDEPTH];
  int                                 held_count;

  queue_result_t pending_results[$];
  op_tag_t       op_tags[$];
  op_row_t       op_table[$];
  int            errors;
  int            ops_accepted;
  bit            calm;

  function automatic queue_result_t apply_op(spq_pkg::func_t op,
                                             logic signed [spq_pkg::VALUE_W-1:0] key);
    queue_result_t r;
    int i;
    r.status = spq_pkg::STATUS_OK;
    r.value = '0;
    r.cleared = '0;
    case (op)
      spq_pkg::FUNC_PUSH: begin
        if (held_count >= QDEPTH) begin
          r.status = spq_pkg::STATUS_FULL;
        end else begin
          i = held_count;
          while (i > 0 && held_keys[i-1] > key) begin
            held_keys[i] = held_keys[i-1];
            i--;
          end
          held_keys[i] = key;
          held_count++;
        end
      end
      spq_pkg::FUNC_POP, spq_pkg::FUNC_PEEK: begin
        if (held_count == 0) begin
          r.status = spq_pkg::STATUS_EMPTY;
        end else begin
          r.value = held_keys[0];
          if (op == spq_pkg::FUNC_POP) begin
            for (i = 1; i < held_count; i++) held_keys[i-1] = held_keys[i];
            held_count--;
          end
        end
      end
      default: begin
        r.cleared = spq_pkg::COUNT_W'(held_count);
        held_count = 0;
      end
    endcase
    r.occupancy = spq_pkg::COUNT_W'(held_count);
    return r;
  endfunction

  function automatic void add_row(spq_pkg::func_t op, logic signed [spq_pkg::VALUE_W-1:0] key,
                                  int reps, bit typed, spq_pkg::status_t st,
                                  logic signed [spq_pkg::VALUE_W-1:0] val, int occ, int clr);
    op_row_t row;
    row.op = op;
    row.key = key;
    row.reps = reps;
    row.typed = typed;
    row.res.status = st;
    row.res.value = val;
    row.res.occupancy = spq_pkg::COUNT_W'(occ);
    row.res.cleared = spq_pkg::COUNT_W'(clr);
    op_table.push_back(row);
  endfunction

  task automatic send_op(spq_pkg::func_t op, logic signed [spq_pkg::VALUE_W-1:0] key,
                         bit typed, queue_result_t res);
    op_tag_t tag;
    tag.typed = typed;
    tag.res = res;
    op_tags.push_back(tag);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= op;
    req_ch.push_value <= key;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Accepted operation beats feed the predictor; result beats are checked in order.
  always @(posedge clk) begin : monitor
    queue_result_t want;
    queue_result_t got;
    op_tag_t tag;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        want = apply_op(spq_pkg::func_t'(req_ch.func), req_ch.push_value);
        if (op_tags.size() != 0) begin
          tag = op_tags.pop_front();
          if (tag.typed) want = tag.res;
        end
        pending_results.push_back(want);
        ops_accepted++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status = spq_pkg::status_t'(rsp_ch.status);
        got.value = rsp_ch.result_value;
        got.occupancy = rsp_ch.occupancy;
        got.cleared = rsp_ch.cleared_count;
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected (status %0d value %0d)",
                   $time, got.status, got.value);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.value !== want.value) begin
            $display("%0t: result_value expected %0d actual %0d", $time, want.value,
                     got.value);
            errors++;
          end
          if (got.occupancy !== want.occupancy) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
                     got.occupancy);
            errors++;
          end
          if (got.cleared !== want.cleared) begin
            $display("%0t: cleared_count expected %0d actual %0d", $time, want.cleared,
                     got.cleared);
            errors++;
          end
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off that backs the queue up.
  initial begin : receiver
    int n;
    bit held;
    held = 1'b0;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!held && ops_accepted >= HOLD_AFTER) begin
        rsp_ch.ready <= 1'b0;
        held = 1'b1;
        n = HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        n = $urandom_range(1, 8);
      end else begin
        rsp_ch.ready <= 1'b1;
        n = $urandom_range(1, 12);
      end
      repeat (n) @(negedge clk);
    end
  end

  initial begin : driver
    logic signed [spq_pkg::VALUE_W-1:0] key;
    spq_pkg::func_t op;
    int mode;
    int pick;
    int small_key;
    int guard;
    queue_result_t none;
    none = '{spq_pkg::STATUS_OK, '0, '0, '0};
    errors = 0;
    ops_accepted = 0;
    held_count = 0;
    calm = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.func = spq_pkg::FUNC_PUSH;
    req_ch.push_value = '0;

    // Rows that repeat push a fresh random key on every repetition.
    add_row(spq_pkg::FUNC_POP,   0,             1,  1, spq_pkg::STATUS_EMPTY, 0,  0, 0);
    add_row(spq_pkg::FUNC_PEEK,  0,             1,  1, spq_pkg::STATUS_EMPTY, 0,  0, 0);
    add_row(spq_pkg::FUNC_CLEAR, 0,             1,  1, spq_pkg::STATUS_OK,    0,  0, 0);
    add_row(spq_pkg::FUNC_PUSH,  32'sh7fffffff, 1,  1, spq_pkg::STATUS_OK,    0,  1, 0);
    add_row(spq_pkg::FUNC_PUSH,  32'sh80000000, 1,  1, spq_pkg::STATUS_OK,    0,  2, 0);
    add_row(spq_pkg::FUNC_PEEK,  0,             1,  1, spq_pkg::STATUS_OK,
            32'sh80000000, 2, 0);
    add_row(spq_pkg::FUNC_PUSH,  0,             1,  1, spq_pkg::STATUS_OK,    0,  3, 0);
    add_row(spq_pkg::FUNC_PUSH,  -1,            1,  1, spq_pkg::STATUS_OK,    0,  4, 0);
    add_row(spq_pkg::FUNC_PUSH,  0,             1,  1, spq_pkg::STATUS_OK,    0,  5, 0);
    add_row(spq_pkg::FUNC_POP,   0,             1,  1, spq_pkg::STATUS_OK,
            32'sh80000000, 4, 0);
    add_row(spq_pkg::FUNC_POP,   0,             1,  1, spq_pkg::STATUS_OK,    -1, 3, 0);
    add_row(spq_pkg::FUNC_POP,   0,             1,  1, spq_pkg::STATUS_OK,    0,  2, 0);
    add_row(spq_pkg::FUNC_POP,   0,             1,  1, spq_pkg::STATUS_OK,    0,  1, 0);
    add_row(spq_pkg::FUNC_POP,   0,             1,  1, spq_pkg::STATUS_OK,
            32'sh7fffffff, 0, 0);
    add_row(spq_pkg::FUNC_PUSH,  1,             1,  1, spq_pkg::STATUS_OK,    0,  1, 0);
    add_row(spq_pkg::FUNC_PUSH,  1,             1,  1, spq_pkg::STATUS_OK,    0,  2, 0);
    add_row(spq_pkg::FUNC_CLEAR, 0,             1,  1, spq_pkg::STATUS_OK,    0,  0, 2);
    add_row(spq_pkg::FUNC_PUSH,  0,             16, 0, spq_pkg::STATUS_OK,    0,  0, 0);
    add_row(spq_pkg::FUNC_PUSH,  32'sh12345678, 1,  1, spq_pkg::STATUS_FULL,  0,  16, 0);
    add_row(spq_pkg::FUNC_PEEK,  0,             1,  0, spq_pkg::STATUS_OK,    0,  0, 0);
    add_row(spq_pkg::FUNC_POP,   0,             1,  0, spq_pkg::STATUS_OK,    0,  0, 0);
    add_row(spq_pkg::FUNC_PUSH,  32'sh55555555, 1,  0, spq_pkg::STATUS_OK,    0,  0, 0);
    add_row(spq_pkg::FUNC_CLEAR, 0,             1,  1, spq_pkg::STATUS_OK,    0,  0, 16);
    add_row(spq_pkg::FUNC_PUSH,  32'shaaaaaaaa, 1,  1, spq_pkg::STATUS_OK,    0,  1, 0);

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    foreach (op_table[r]) begin
      for (int k = 0; k < op_table[r].reps; k++) begin
        key = (op_table[r].reps > 1) ? spq_pkg::VALUE_W'($urandom) : op_table[r].key;
        send_op(op_table[r].op, key, op_table[r].typed, op_table[r].res);
      end
    end

    // Random part in blocks that lean toward filling, draining or neither, so the
    // occupancy sweeps between empty and full.
    mode = 0;
    for (int n = 0; n < RAND_OPS; n++) begin
      if (n % 40 == 0) mode = $urandom_range(0, 2);
      if (n == RAND_OPS - CALM_TAIL) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        op = spq_pkg::FUNC_CLEAR;
      end else if (pick < (mode == 0 ? 75 : (mode == 1 ? 30 : 52))) begin
        op = spq_pkg::FUNC_PUSH;
      end else begin
        op = ($urandom_range(0, 2) == 0) ? spq_pkg::FUNC_PEEK : spq_pkg::FUNC_POP;
      end
      case ($urandom_range(0, 7))
        0: begin
          case ($urandom_range(0, 3))
            0: key = 32'sh80000000;
            1: key = 32'sh7fffffff;
            2: key = '0;
            default: key = '1;
          endcase
        end
        1, 2: begin
          small_key = $urandom_range(0, 6);
          key = small_key - 3;
        end
        default: key = spq_pkg::VALUE_W'($urandom);
      endcase
      send_op(op, key, 1'b0, none);
    end
    req_ch.valid <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
